### rtl/core/gnfbm_pkg.sv
// ----------------------------------------------------------------------------
// gnfbm_pkg
// Shared constants, register codes and the permutation ROM of the fractal
// gradient noise unit.
// ----------------------------------------------------------------------------
package gnfbm_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int COORD_WIDTH_DEF = 12;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int FREQ_W   = 16;
  localparam int OCT_W    = 4;
  localparam int ZPLANE_W = 24;
  localparam int SCALE_W  = 9;
  localparam int CFG_W    = 24;
  localparam int NOISE_W  = 8;

  localparam logic [FREQ_W-1:0]   FREQ_RST   = 16'd1311;
  localparam logic [OCT_W-1:0]    OCT_RST    = 4'd4;
  localparam logic [ZPLANE_W-1:0] ZPLANE_RST = 24'd0;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 9'd256;

  localparam logic [NOISE_W-1:0] NOISE_MAX = 8'd255;

  // lane depth is 11, plus input, scale, two sum, clamp and output stages
  localparam int OCT_DEPTH = 11;
  localparam int LATENCY   = OCT_DEPTH + 6;

  typedef enum logic [1:0] {
    CFG_FREQUENCY    = 2'd0,
    CFG_OCTAVE_COUNT = 2'd1,
    CFG_Z_PLANE      = 2'd2,
    CFG_OUTPUT_SCALE = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

endpackage

### rtl/core/gnfbm_octave.sv
// ----------------------------------------------------------------------------
// gnfbm_octave
// One octave of 3-D improved gradient noise, eleven register stages:
// lattice split, hashing and fade, gradients, then three lerp levels.
// ----------------------------------------------------------------------------
module gnfbm_octave #(
  parameter int COORD_WIDTH = gnfbm_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = gnfbm_pkg::FRAC_BITS_DEF,
  parameter int OCT_INDEX   = 0
) (
  input  logic                         clk,
  input  logic [COORD_WIDTH+15:0]      xs_i,
  input  logic [COORD_WIDTH+15:0]      ys_i,
  input  logic [FRAC_BITS+7:0]         zc_i,
  output logic signed [FRAC_BITS+1:0]  noise_o
);
  import gnfbm_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int PW = F + 2;
  localparam int DW = 2 * F + 5;
  localparam int IW = F + 5;
  localparam int XE = COORD_WIDTH + OCT_INDEX + F + 24;
  localparam logic signed [PW-1:0] ONE_S = {2'b01, {F{1'b0}}};

  function automatic logic signed [PW-1:0] grad(input logic [3:0] h,
      input logic signed [PW-1:0] gx, input logic signed [PW-1:0] gy,
      input logic signed [PW-1:0] gz);
    logic signed [PW-1:0] gu;
    logic signed [PW-1:0] gv;
    gu = (h < 4'd8) ? gx : gy;
    gv = (h < 4'd4) ? gy : ((h == 4'd12 || h == 4'd14) ? gx : gz);
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  function automatic logic [3:0] ghash(input logic [7:0] idx);
    logic [7:0] pv;
    pv = perm_lookup(idx);
    return pv[3:0];
  endfunction

  function automatic logic signed [DW-1:0] lmul(input logic signed [PW-1:0] a,
      input logic signed [PW-1:0] b, input logic [F:0] t);
    logic signed [PW:0]  df;
    logic signed [F+1:0] ts;
    df = (PW+1)'(b) - (PW+1)'(a);
    ts = {1'b0, t};
    return DW'(df) * DW'(ts);
  endfunction

  logic [XE-1:0]    xe, ye;
  logic [F+7:0]     crd [3];
  logic [2*F-1:0]   sq  [3];
  logic [2*F-1:0]   cu  [3];
  logic [IW-1:0]    inr [3];
  logic [2*F+4:0]   fp  [3];
  logic signed [PW-1:0] o0 [3];
  logic signed [PW-1:0] o1 [3];

  logic [7:0]       i1_r [3];
  logic [F-1:0]     f1_r [3];
  logic [7:0]       a2_r, b2_r, iz2_r;
  logic [F-1:0]     f2_r [3];
  logic [F-1:0]     t2_r [3];
  logic [7:0]       aa3_r, ab3_r, ba3_r, bb3_r;
  logic [F-1:0]     f3_r [3];
  logic [F-1:0]     t3_r [3];
  logic [IW-1:0]    in3_r [3];
  logic [3:0]       h4_r [8];
  logic [F-1:0]     f4_r [3];
  logic [F:0]       fd4_r [3];
  logic signed [PW-1:0] p5_r [8];
  logic [F:0]       fd5_r [3];
  logic signed [DW-1:0] d6_r [4];
  logic signed [PW-1:0] pe6_r [4];
  logic [F:0]       v6_r, w6_r;
  logic signed [PW-1:0] q7_r [4];
  logic [F:0]       v7_r, w7_r;
  logic signed [DW-1:0] e8_r [2];
  logic signed [PW-1:0] qe8_r [2];
  logic [F:0]       w8_r;
  logic signed [PW-1:0] r9_r [2];
  logic [F:0]       w9_r;
  logic signed [DW-1:0] g10_r;
  logic signed [PW-1:0] r10_r;
  logic signed [PW-1:0] n11_r;

  always_comb begin
    xe = XE'(xs_i) << (OCT_INDEX + F);
    ye = XE'(ys_i) << (OCT_INDEX + F);
    crd[0] = xe[16 +: F+8];
    crd[1] = ye[16 +: F+8];
    crd[2] = zc_i;
    for (int k = 0; k < 3; k++) begin
      sq[k]  = (2*F)'(f1_r[k]) * (2*F)'(f1_r[k]);
      cu[k]  = (2*F)'(t2_r[k]) * (2*F)'(f2_r[k]);
      inr[k] = IW'(6) * IW'(t2_r[k]) + (IW'(10) << F) - IW'(15) * IW'(f2_r[k]);
      fp[k]  = (2*F+5)'(t3_r[k]) * (2*F+5)'(in3_r[k]);
      o0[k]  = PW'(f4_r[k]);
      o1[k]  = PW'(f4_r[k]) - ONE_S;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      i1_r[k]  <= crd[k][F +: 8];
      f1_r[k]  <= crd[k][F-1:0];
      f2_r[k]  <= f1_r[k];
      t2_r[k]  <= sq[k][F +: F];
      f3_r[k]  <= f2_r[k];
      t3_r[k]  <= cu[k][F +: F];
      in3_r[k] <= inr[k];
      f4_r[k]  <= f3_r[k];
      fd4_r[k] <= fp[k][F +: F+1];
      fd5_r[k] <= fd4_r[k];
    end
    a2_r  <= perm_lookup(i1_r[0]) + i1_r[1];
    b2_r  <= perm_lookup(i1_r[0] + 8'd1) + i1_r[1];
    iz2_r <= i1_r[2];
    aa3_r <= perm_lookup(a2_r) + iz2_r;
    ab3_r <= perm_lookup(a2_r + 8'd1) + iz2_r;
    ba3_r <= perm_lookup(b2_r) + iz2_r;
    bb3_r <= perm_lookup(b2_r + 8'd1) + iz2_r;
    h4_r[0] <= ghash(aa3_r);
    h4_r[1] <= ghash(ba3_r);
    h4_r[2] <= ghash(ab3_r);
    h4_r[3] <= ghash(bb3_r);
    h4_r[4] <= ghash(aa3_r + 8'd1);
    h4_r[5] <= ghash(ba3_r + 8'd1);
    h4_r[6] <= ghash(ab3_r + 8'd1);
    h4_r[7] <= ghash(bb3_r + 8'd1);
    p5_r[0] <= grad(h4_r[0], o0[0], o0[1], o0[2]);
    p5_r[1] <= grad(h4_r[1], o1[0], o0[1], o0[2]);
    p5_r[2] <= grad(h4_r[2], o0[0], o1[1], o0[2]);
    p5_r[3] <= grad(h4_r[3], o1[0], o1[1], o0[2]);
    p5_r[4] <= grad(h4_r[4], o0[0], o0[1], o1[2]);
    p5_r[5] <= grad(h4_r[5], o1[0], o0[1], o1[2]);
    p5_r[6] <= grad(h4_r[6], o0[0], o1[1], o1[2]);
    p5_r[7] <= grad(h4_r[7], o1[0], o1[1], o1[2]);
    for (int j = 0; j < 4; j++) begin
      d6_r[j]  <= lmul(p5_r[2*j], p5_r[2*j+1], fd5_r[0]);
      pe6_r[j] <= p5_r[2*j];
      q7_r[j]  <= pe6_r[j] + PW'(d6_r[j] >>> F);
    end
    v6_r <= fd5_r[1];
    w6_r <= fd5_r[2];
    v7_r <= v6_r;
    w7_r <= w6_r;
    for (int j = 0; j < 2; j++) begin
      e8_r[j]  <= lmul(q7_r[2*j], q7_r[2*j+1], v7_r);
      qe8_r[j] <= q7_r[2*j];
      r9_r[j]  <= qe8_r[j] + PW'(e8_r[j] >>> F);
    end
    w8_r  <= w7_r;
    w9_r  <= w8_r;
    g10_r <= lmul(r9_r[0], r9_r[1], w9_r);
    r10_r <= r9_r[0];
    n11_r <= r10_r + PW'(g10_r >>> F);
  end

  assign noise_o = n11_r;

endmodule

### rtl/core/gradient_noise_fbm_2d_unit.sv
// ----------------------------------------------------------------------------
// gradient_noise_fbm_2d_unit
// Fractal gradient noise per pixel: one octave pipeline per octave, summed,
// clamped and scaled to an 8-bit grey level.
//
//   channel   ports                                   handshake
//   request   in_x_coord, in_y_coord                  start & !busy
//   result    out_noise_value                         out_valid, one cycle
//   config    cfg_index, cfg_wdata                    cfg_we
//
// One request per cycle; a result passes the input and scale stages, the
// eleven-stage octave pipeline and the two sum, clamp and output stages.
// busy is never raised. Reset clears valid bits and loads register defaults.
// The receiver cannot stall; results leave on out_valid.
// ----------------------------------------------------------------------------
module gradient_noise_fbm_2d_unit #(
  parameter int MAX_OCTAVES = gnfbm_pkg::MAX_OCTAVES_DEF,
  parameter int COORD_WIDTH = gnfbm_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = gnfbm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_WIDTH-1:0]        in_x_coord,
  input  logic [COORD_WIDTH-1:0]        in_y_coord,
  output logic                          out_valid,
  output logic [gnfbm_pkg::NOISE_W-1:0] out_noise_value,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [gnfbm_pkg::CFG_W-1:0]   cfg_wdata
);
  import gnfbm_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int PW  = F + 2;
  localparam int SW  = F + 6;
  localparam int XSW = COORD_WIDTH + 16;
  localparam int ZE  = ZPLANE_W + F + 8;
  localparam int NG  = (MAX_OCTAVES + 3) / 4;
  localparam int PRW = F + 1 + SCALE_W;
  localparam logic signed [SW-1:0] ONE_S = SW'(1) <<< F;

  logic [FREQ_W-1:0]   freq_r;
  logic [OCT_W-1:0]    oct_r;
  logic [ZPLANE_W-1:0] zpl_r;
  logic [SCALE_W-1:0]  scale_r;

  logic [LATENCY-1:0]     vld_r;
  logic [COORD_WIDTH-1:0] x_r, y_r;
  logic [XSW-1:0]         xs_r, ys_r;
  logic [ZE-1:0]          ze;
  logic [F+7:0]           zc;

  logic signed [PW-1:0] lane_n [MAX_OCTAVES];
  logic signed [SW-1:0] part_nxt [NG];
  logic signed [SW-1:0] part_r [NG];
  logic signed [SW-1:0] sum_nxt, sum_r, sum_off;
  logic [F:0]           m_nxt, m_r;
  logic [PRW-1:0]       prod;
  logic [PRW-F-1:0]     prod_hi;
  logic [NOISE_W-1:0]   out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= FREQ_RST;
      oct_r   <= OCT_RST;
      zpl_r   <= ZPLANE_RST;
      scale_r <= SCALE_RST;
      vld_r   <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], start & ~busy};
      if (cfg_we) begin
        case (cfg_index)
          CFG_FREQUENCY:    freq_r  <= cfg_wdata[FREQ_W-1:0];
          CFG_OCTAVE_COUNT: oct_r   <= cfg_wdata[OCT_W-1:0];
          CFG_Z_PLANE:      zpl_r   <= cfg_wdata[ZPLANE_W-1:0];
          CFG_OUTPUT_SCALE: scale_r <= cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= in_x_coord;
    y_r  <= in_y_coord;
    xs_r <= XSW'(x_r) * XSW'(freq_r);
    ys_r <= XSW'(y_r) * XSW'(freq_r);
  end

  always_comb begin
    ze = ZE'(zpl_r) << F;
    zc = ze[16 +: F+8];
  end

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    gnfbm_octave #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .OCT_INDEX   (i)
    ) u_oct (
      .clk     (clk),
      .xs_i    (xs_r),
      .ys_i    (ys_r),
      .zc_i    (zc),
      .noise_o (lane_n[i])
    );
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < MAX_OCTAVES) begin
          if (int'(oct_r) > g * 4 + k) begin
            part_nxt[g] = part_nxt[g] + (SW'(lane_n[g*4+k]) >>> (g * 4 + k));
          end
        end
      end
    end
    sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      sum_nxt = sum_nxt + part_r[g];
    end
    sum_off = sum_r + ONE_S;
    if (sum_r <= -ONE_S) begin
      m_nxt = '0;
    end else if (sum_r > ONE_S) begin
      m_nxt = ONE_S[F:0];
    end else begin
      m_nxt = sum_off[F+1:1];
    end
    prod    = PRW'(m_r) * PRW'(scale_r);
    prod_hi = prod[PRW-1:F];
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
    sum_r  <= sum_nxt;
    m_r    <= m_nxt;
    out_r  <= (prod_hi > (PRW-F)'(NOISE_MAX)) ? NOISE_MAX : prod_hi[NOISE_W-1:0];
  end

  assign busy            = 1'b0;
  assign out_valid       = vld_r[LATENCY-1];
  assign out_noise_value = out_r;

endmodule

### rtl/core/gnfbm_chk.sv
// ----------------------------------------------------------------------------
// gnfbm_chk
// Port-level checks of the noise unit: fixed latency, no spurious results, busy never raised.
// ----------------------------------------------------------------------------
module gnfbm_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import gnfbm_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result without request");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind gradient_noise_fbm_2d_unit gnfbm_chk u_gnfbm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
